/* design/fscc_pkg.sv */
// Shared types and constants for the flash save command controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package fscc_pkg;

  // Address and store geometry. All sizes are powers of two.
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int ID_W        = 16;
  localparam int SRAM_AW     = 15;              // 32 KiB battery-backed SRAM
  localparam int BANK_AW     = 16;              // 64 KiB per flash bank
  localparam int SECTOR_AW   = 12;              // 4 KiB erase sector
  localparam int STORE_AW    = BANK_AW + 1;     // two banks
  localparam int STORE_BYTES = 1 << STORE_AW;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_FLASH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 2'd2;

  // Save kinds.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SRAM  = 2'd1;
  localparam logic [1:0] KIND_FLASH = 2'd2;

  // Flash modes.
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_ID    = 3'd1;
  localparam logic [2:0] MODE_ERASE = 3'd2;
  localparam logic [2:0] MODE_PROG  = 3'd3;
  localparam logic [2:0] MODE_BANK  = 3'd4;

  // Unlock sequence steps.
  localparam logic [1:0] STEP_LOCKED   = 2'd0;
  localparam logic [1:0] STEP_FIRST    = 2'd1;
  localparam logic [1:0] STEP_UNLOCKED = 2'd2;

  // Command protocol addresses and bytes.
  localparam logic [ADDR_W-1:0] CMD_ADDR     = 16'h5555;
  localparam logic [ADDR_W-1:0] UNLOCK2_ADDR = 16'h2AAA;
  localparam logic [DATA_W-1:0] UNLOCK1_BYTE = 8'hAA;
  localparam logic [DATA_W-1:0] UNLOCK2_BYTE = 8'h55;
  localparam logic [DATA_W-1:0] CMD_CHIP_ERASE   = 8'h10;
  localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 8'h30;
  localparam logic [DATA_W-1:0] CMD_ID_ENTER     = 8'h90;
  localparam logic [DATA_W-1:0] CMD_RESET        = 8'hF0;
  localparam logic [DATA_W-1:0] CMD_ERASE        = 8'h80;
  localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'hA0;
  localparam logic [DATA_W-1:0] CMD_BANK_SELECT  = 8'hB0;

  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;  // capture the accepted item
    logic exec;       // run the item against the store and protocol state
    logic sweep;      // write one erased byte and advance the sweep address
    logic respond;    // load the result register
  } fscc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic erase_req;   // the held item starts an erase
    logic sweep_last;  // the sweep address is at the last byte
    logic out_free;    // the result register can take a new item
  } fscc_status_t;

endpackage

/* design/fscc_ram.sv */
// Generic single-port RAM with a registered read port.
// Stand-alone; used for the save store.
module fscc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, or read into the output register, when enabled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fscc_ctrl.sv */
// Sequencer for the flash save command controller.
// Depends on fscc_pkg for the command and status types.
module fscc_ctrl
  import fscc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  fscc_status_t status_i,
  output fscc_cmd_t    cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.erase_req ? ST_SWEEP : ST_RESP;
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass over the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted item is always executed in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted item not executed");

  // The result register is never overwritten while it still holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.respond |-> status_i.out_free)
    else $error("result loaded into a full register");

  // An erase sweep always ends with a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && status_i.sweep_last) |=> (state_q == ST_RESP))
    else $error("erase sweep did not end in a result");

endmodule

/* design/fscc_datapath.sv */
// Datapath of the flash save command controller: configuration, flash
// command state, erase sweep counter, save store and result register.
// Depends on fscc_pkg and fscc_ram.
module fscc_datapath
  import fscc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ID_W-1:0]      cfg_data_i,
  input  logic                 op_i,
  input  logic [ADDR_W-1:0]    addr_i,
  input  logic [DATA_W-1:0]    wdata_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [DATA_W-1:0]    rdata_o,
  input  fscc_cmd_t            cmd_i,
  output fscc_status_t         status_o
);

  // Configuration registers.
  logic [1:0]      save_kind_q;
  logic            big_flash_q;
  logic [ID_W-1:0] device_id_q;

  // Held item.
  logic              item_op_q;
  logic [ADDR_W-1:0] item_addr_q;
  logic [DATA_W-1:0] item_wdata_q;

  // Flash command state.
  logic [1:0] step_q, step_d;
  logic [2:0] mode_q, mode_d, mode_eff;
  logic       bank_sel_q, bank_sel_d;

  // Sweep range and result register.
  logic [STORE_AW-1:0] sweep_addr_q, sweep_end_q;
  logic                out_valid_q;
  logic [DATA_W-1:0]   rdata_q;

  logic                flash_wr, prog_we, erase_req, erase_chip, erase_hit;
  logic                bank;
  logic [STORE_AW-1:0] flash_idx, sram_idx, item_idx;
  logic [STORE_AW-1:0] sector_start, sector_end, erase_start, erase_end;
  logic                ram_en, ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata, resp_data;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      save_kind_q <= KIND_FLASH;
      big_flash_q <= 1'b0;
      device_id_q <= 16'hD4BF;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SAVE_KIND: save_kind_q <= cfg_data_i[1:0];
        CFG_BIG_FLASH: big_flash_q <= cfg_data_i[0];
        CFG_DEVICE_ID: device_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_op_q    <= op_i;
      item_addr_q  <= addr_i;
      item_wdata_q <= wdata_i;
    end
  end

  // Store addressing for both save kinds.
  assign bank      = bank_sel_q & big_flash_q;
  assign flash_idx = {bank, item_addr_q[BANK_AW-1:0]};
  assign sram_idx  = STORE_AW'(item_addr_q[SRAM_AW-1:0]);
  assign item_idx  = (save_kind_q == KIND_SRAM) ? sram_idx : flash_idx;

  // Sector bounds within the current bank.
  assign sector_start = {bank, item_addr_q[BANK_AW-1:SECTOR_AW], {SECTOR_AW{1'b0}}};
  assign sector_end   = {bank, item_addr_q[BANK_AW-1:SECTOR_AW], {SECTOR_AW{1'b1}}};

  assign mode_eff = (mode_q > MODE_BANK) ? MODE_IDLE : mode_q;
  assign flash_wr = item_op_q && (save_kind_q == KIND_FLASH);
  assign erase_hit = (mode_eff == MODE_ERASE) &&
                     (((item_addr_q == CMD_ADDR) && (item_wdata_q == CMD_CHIP_ERASE)) ||
                      (item_wdata_q == CMD_SECTOR_ERASE));

  // Flash command protocol for a write to the held item.
  always_comb begin
    step_d     = step_q;
    mode_d     = mode_q;
    bank_sel_d = bank_sel_q;
    prog_we    = 1'b0;
    erase_req  = 1'b0;
    erase_chip = 1'b0;
    if (flash_wr) begin
      priority if (mode_eff == MODE_PROG) begin
        prog_we = 1'b1;
        mode_d  = MODE_IDLE;
      end else if (mode_eff == MODE_BANK) begin
        bank_sel_d = item_wdata_q[0];
        mode_d     = MODE_IDLE;
      end else if (step_q == STEP_FIRST) begin
        if (item_addr_q == UNLOCK2_ADDR && item_wdata_q == UNLOCK2_BYTE) begin
          step_d = STEP_UNLOCKED;
        end
      end else if (step_q != STEP_UNLOCKED) begin
        if (item_addr_q == CMD_ADDR && item_wdata_q == UNLOCK1_BYTE) begin
          step_d = STEP_FIRST;
        end else begin
          step_d = STEP_LOCKED;
        end
      end else if (erase_hit) begin
        erase_req  = 1'b1;
        erase_chip = (item_addr_q == CMD_ADDR) && (item_wdata_q == CMD_CHIP_ERASE);
        step_d     = STEP_LOCKED;
        mode_d     = MODE_IDLE;
      end else if (item_addr_q == CMD_ADDR) begin
        step_d = STEP_LOCKED;
        unique case (item_wdata_q)
          CMD_ID_ENTER:    mode_d = MODE_ID;
          CMD_RESET:       mode_d = MODE_IDLE;
          CMD_ERASE:       mode_d = MODE_ERASE;
          CMD_PROGRAM:     mode_d = MODE_PROG;
          CMD_BANK_SELECT: mode_d = big_flash_q ? MODE_BANK : mode_q;
          default:         mode_d = mode_q;
        endcase
      end else begin
        // A stray write while unlocked keeps the sequence unlocked.
      end
    end
  end

  // Protocol state updates when the item executes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= STEP_LOCKED;
      mode_q     <= MODE_IDLE;
      bank_sel_q <= 1'b0;
    end else if (cmd_i.exec) begin
      step_q     <= step_d;
      mode_q     <= mode_d;
      bank_sel_q <= bank_sel_d;
    end
  end

  // Erase range: the whole chip or one sector.
  assign erase_start = erase_chip ? '0 : sector_start;
  assign erase_end   = erase_chip ? {big_flash_q, {BANK_AW{1'b1}}} : sector_end;

  // Sweep counter; out of reset it covers the whole store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_addr_q <= '0;
      sweep_end_q  <= '1;
    end else if (cmd_i.exec && erase_req) begin
      sweep_addr_q <= erase_start;
      sweep_end_q  <= erase_end;
    end else if (cmd_i.sweep) begin
      sweep_addr_q <= sweep_addr_q + STORE_AW'(1);
    end
  end

  // Store port: sweep writes erased bytes, otherwise the held item accesses it.
  assign ram_en    = cmd_i.sweep || cmd_i.exec;
  assign ram_we    = cmd_i.sweep ||
                     (item_op_q && ((save_kind_q == KIND_SRAM) || prog_we));
  assign ram_addr  = cmd_i.sweep ? sweep_addr_q : item_idx;
  assign ram_wdata = cmd_i.sweep ? ERASED_BYTE : item_wdata_q;

  fscc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Read result by save kind; writes return zero.
  always_comb begin
    if (item_op_q) begin
      resp_data = '0;
    end else if (save_kind_q == KIND_SRAM) begin
      resp_data = ram_rdata;
    end else if (save_kind_q == KIND_FLASH) begin
      if (mode_eff == MODE_ID) begin
        resp_data = item_addr_q[0] ? device_id_q[15:8] : device_id_q[7:0];
      end else begin
        resp_data = ram_rdata;
      end
    end else begin
      resp_data = ERASED_BYTE;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.respond) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      rdata_q <= resp_data;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign rdata_o             = rdata_q;
  assign status_o.erase_req  = erase_req;
  assign status_o.sweep_last = (sweep_addr_q == sweep_end_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // The unlock step never reaches its unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_UNLOCKED)
    else $error("unlock step left the sequence");

  // An erase starts only from a flash write with the sequence unlocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && erase_req) |-> (flash_wr && step_q == STEP_UNLOCKED))
    else $error("erase started outside an unlocked flash write");

  // A sweep range never starts past its end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && erase_req) |=> (sweep_addr_q <= sweep_end_q))
    else $error("erase range is inverted");

endmodule

/* design/flash_save_command_controller.sv */
// Top level of the flash save command controller.
// Depends on fscc_pkg, fscc_ctrl, fscc_datapath and fscc_ram.
//
// Byte-wide save-memory port for a cartridge bus. Each item is one read or
// write. An item is accepted in the idle cycle and runs against the store in
// the next cycle; after any erase sweep it loads the result register, which
// happens only once the previous result has been taken, so output stalls
// delay it. No new item is accepted until then. A new item is taken in the
// cycle after the result is loaded, even while that result still waits to be
// taken. The save store is a single-port 128 KiB memory, so erases run one
// byte per cycle through it: a sector erase sweeps 4096 bytes and a chip
// erase 65536 bytes (131072 with two banks). After reset the block first
// sweeps the whole store to 0xFF, during which no item is accepted;
// configuration writes are taken at any time.
module flash_save_command_controller
  import fscc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ID_W-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic [ADDR_W-1:0]    addr_i,
  input  logic [DATA_W-1:0]    wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DATA_W-1:0]    rdata_o
);

  fscc_cmd_t    cmd;
  fscc_status_t status;

  // Configuration is always writable.
  assign cfg_ready_o = 1'b1;

  fscc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fscc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (op_i),
    .addr_i      (addr_i),
    .wdata_i     (wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .rdata_o     (rdata_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the flash save command controller.
// Depends on fscc_pkg and flash_save_command_controller, with its fscc_ctrl, fscc_datapath and fscc_ram.
module tb;
  import fscc_pkg::*;

  localparam logic       OP_READ     = 1'b0;
  localparam logic       OP_WRITE    = 1'b1;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 3_000_000;
  localparam int         QUIET_GAP   = 16;
  localparam logic [1:0] STALL_NONE   = 2'd0;
  localparam logic [1:0] STALL_COIN   = 2'd1;
  localparam logic [1:0] STALL_SPARSE = 2'd2;
  localparam logic [1:0] STALL_RARE   = 2'd3;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              hold;  // wait for every pending result before this item
  } bus_access_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ID_W-1:0]      cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 op_i = 1'b0;
  logic [ADDR_W-1:0]    addr_i = '0;
  logic [DATA_W-1:0]    wdata_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [DATA_W-1:0]    rdata_o;

  flash_save_command_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .addr_i      (addr_i),
    .wdata_i     (wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rdata_o     (rdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the save memory and protocol state, plus the register copies.
  logic [DATA_W-1:0] save_mirror [0:STORE_BYTES-1];
  logic [1:0]        mirror_step = STEP_LOCKED;
  logic [2:0]        mirror_mode = MODE_IDLE;
  logic              mirror_bank = 1'b0;
  logic [1:0]        cfg_kind = KIND_FLASH;
  logic              cfg_big = 1'b0;
  logic [ID_W-1:0]   cfg_id = 16'hD4BF;

  bus_access_t       bus_plan [$];
  logic [DATA_W-1:0] rdata_due [$];
  logic [DATA_W-1:0] due_rdata;
  bus_access_t       next_access;
  int                outstanding = 0;
  int                mismatches = 0;
  int                cycle_count = 0;
  int                burst_left = 8;
  int                gap_left = 0;
  int                stall_tick = 0;
  logic [1:0]        stall_style = STALL_NONE;
  logic              hold_next = 1'b0;
  int                phase_items = 0;
  int                sector_budget = 30;
  int                chip_budget = 1;
  logic [ADDR_W-1:0] hot_addr [0:15];

  // Runs one bus access against the mirror and returns the byte it reads.
  function automatic logic [DATA_W-1:0] access_save_mirror(input logic op,
                                                           input logic [ADDR_W-1:0] addr,
                                                           input logic [DATA_W-1:0] data);
    logic [STORE_AW-1:0] flash_at;
    logic [DATA_W-1:0]   rd;
    int                  base;
    int                  i;
    flash_at = {mirror_bank & cfg_big, addr};
    rd = '0;
    if (op == OP_READ) begin
      if (cfg_kind == KIND_SRAM) begin
        rd = save_mirror[{2'b00, addr[SRAM_AW-1:0]}];
      end else if (cfg_kind == KIND_FLASH) begin
        if (mirror_mode == MODE_ID) begin
          rd = addr[0] ? cfg_id[15:8] : cfg_id[7:0];
        end else begin
          rd = save_mirror[flash_at];
        end
      end else begin
        rd = ERASED_BYTE;
      end
    end else if (cfg_kind == KIND_SRAM) begin
      save_mirror[{2'b00, addr[SRAM_AW-1:0]}] = data;
    end else if (cfg_kind == KIND_FLASH) begin
      // Program and bank select take the next write whatever the unlock step.
      if (mirror_mode == MODE_PROG) begin
        save_mirror[flash_at] = data;
        mirror_mode = MODE_IDLE;
      end else if (mirror_mode == MODE_BANK) begin
        mirror_bank = data[0];
        mirror_mode = MODE_IDLE;
      end else if (mirror_step == STEP_FIRST) begin
        if (addr == UNLOCK2_ADDR && data == UNLOCK2_BYTE) mirror_step = STEP_UNLOCKED;
      end else if (mirror_step != STEP_UNLOCKED) begin
        if (addr == CMD_ADDR && data == UNLOCK1_BYTE) mirror_step = STEP_FIRST;
      end else if (mirror_mode == MODE_ERASE && addr == CMD_ADDR &&
                   data == CMD_CHIP_ERASE) begin
        for (i = 0; i < (cfg_big ? STORE_BYTES : STORE_BYTES / 2); i++) begin
          save_mirror[i] = ERASED_BYTE;
        end
        mirror_step = STEP_LOCKED;
        mirror_mode = MODE_IDLE;
      end else if (mirror_mode == MODE_ERASE && data == CMD_SECTOR_ERASE) begin
        base = int'({mirror_bank & cfg_big, addr[BANK_AW-1:SECTOR_AW], {SECTOR_AW{1'b0}}});
        for (i = 0; i < (1 << SECTOR_AW); i++) begin
          save_mirror[base + i] = ERASED_BYTE;
        end
        mirror_step = STEP_LOCKED;
        mirror_mode = MODE_IDLE;
      end else if (addr == CMD_ADDR) begin
        // Any command write relocks; unknown bytes leave the mode alone.
        mirror_step = STEP_LOCKED;
        case (data)
          CMD_ID_ENTER:    mirror_mode = MODE_ID;
          CMD_RESET:       mirror_mode = MODE_IDLE;
          CMD_ERASE:       mirror_mode = MODE_ERASE;
          CMD_PROGRAM:     mirror_mode = MODE_PROG;
          CMD_BANK_SELECT: if (cfg_big) mirror_mode = MODE_BANK;
          default: ;
        endcase
      end
    end
    return rd;
  endfunction

  // Random byte that can never start an erase.
  function automatic logic [DATA_W-1:0] safe_byte();
    logic [DATA_W-1:0] b;
    b = DATA_W'($urandom_range(0, 255));
    if (b == CMD_CHIP_ERASE || b == CMD_SECTOR_ERASE) b[0] = 1'b1;
    return b;
  endfunction

  // Mostly a small set of addresses so reads meet earlier writes; flipping the
  // top bit exercises SRAM aliasing.
  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [ADDR_W-1:0] a;
    if ($urandom_range(0, 3) == 0) a = ADDR_W'($urandom_range(0, 65535));
    else a = hot_addr[$urandom_range(0, 15)];
    if ($urandom_range(0, 3) == 0) a[ADDR_W-1] = ~a[ADDR_W-1];
    return a;
  endfunction

  task automatic queue_access(input logic op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
    bus_access_t acc;
    acc.op = op;
    acc.addr = addr;
    acc.data = data;
    acc.hold = hold_next;
    hold_next = 1'b0;
    bus_plan.push_back(acc);
    phase_items++;
  endtask

  task automatic queue_unlock();
    queue_access(OP_WRITE, CMD_ADDR, UNLOCK1_BYTE);
    queue_access(OP_WRITE, UNLOCK2_ADDR, UNLOCK2_BYTE);
  endtask

  task automatic queue_command(input logic [DATA_W-1:0] cmd);
    queue_unlock();
    queue_access(OP_WRITE, CMD_ADDR, cmd);
  endtask

  // Flash traffic: well-formed command sequences with random content, plain
  // reads, broken sequences and noise.
  task automatic gen_flash_traffic(input int n, input logic chip_ok);
    int   pick;
    logic held;
    held = 1'b0;
    phase_items = 0;
    while (phase_items < n) begin
      if ((!held && phase_items >= n / 2) || $urandom_range(0, 49) == 0) begin
        hold_next = 1'b1;
        held = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        queue_command(CMD_PROGRAM);
        queue_access(OP_WRITE, pick_addr(), DATA_W'($urandom_range(0, 255)));
      end else if (pick < 52) begin
        queue_access(OP_READ, pick_addr(), DATA_W'($urandom_range(0, 255)));
      end else if (pick < 60) begin
        queue_command(CMD_ID_ENTER);
        repeat ($urandom_range(1, 3)) begin
          queue_access(OP_READ, ADDR_W'($urandom_range(0, 65535)),
                       DATA_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) != 0) queue_command(CMD_RESET);
      end else if (pick < 66) begin
        queue_command(CMD_BANK_SELECT);
        queue_access(OP_WRITE, pick_addr(), DATA_W'($urandom_range(0, 255)));
      end else if (pick < 70 && sector_budget > 0) begin
        sector_budget--;
        queue_command(CMD_ERASE);
        queue_unlock();
        queue_access(OP_WRITE, pick_addr(), CMD_SECTOR_ERASE);
      end else if (pick == 70 && chip_ok && chip_budget > 0) begin
        chip_budget--;
        queue_command(CMD_ERASE);
        queue_unlock();
        queue_access(OP_WRITE, CMD_ADDR, CMD_CHIP_ERASE);
      end else if (pick < 86) begin
        case ($urandom_range(0, 3))
          0: queue_access(OP_WRITE, CMD_ADDR, UNLOCK1_BYTE);
          1: begin
            queue_access(OP_WRITE, CMD_ADDR, UNLOCK1_BYTE);
            queue_access(OP_WRITE, UNLOCK2_ADDR, safe_byte());
          end
          2: begin
            queue_unlock();
            queue_access(OP_WRITE, pick_addr(), safe_byte());
          end
          default: queue_command(safe_byte());
        endcase
      end else begin
        queue_access(1'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 65535)),
                     safe_byte());
      end
    end
  endtask

  // Plain reads and writes for the SRAM and no-memory kinds.
  task automatic gen_plain_traffic(input int n);
    logic held;
    held = 1'b0;
    phase_items = 0;
    while (phase_items < n) begin
      if ((!held && phase_items >= n / 2) || $urandom_range(0, 49) == 0) begin
        hold_next = 1'b1;
        held = 1'b1;
      end
      queue_access(1'($urandom_range(0, 1)), pick_addr(), DATA_W'($urandom_range(0, 255)));
    end
  endtask

  // Waits until every planned item is taken and answered, then a short pause.
  task automatic wait_quiet();
    do @(negedge clk_i); while (bus_plan.size() != 0 || in_valid_i || outstanding != 0);
    repeat (QUIET_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] kind, input logic big, input logic [ID_W-1:0] id);
    wait_quiet();
    write_reg(CFG_SAVE_KIND, {{(ID_W-2){1'b0}}, kind});
    write_reg(CFG_BIG_FLASH, {{(ID_W-1){1'b0}}, big});
    write_reg(CFG_DEVICE_ID, id);
    @(negedge clk_i);
  endtask

  // Stimulus plan: directed accesses first, then random phases per setting.
  initial begin
    for (int i = 0; i < STORE_BYTES; i++) save_mirror[i] = ERASED_BYTE;
    hot_addr[0] = 16'h0000;
    hot_addr[1] = 16'hFFFF;
    hot_addr[2] = CMD_ADDR;
    hot_addr[3] = UNLOCK2_ADDR;
    hot_addr[4] = 16'h7FFF;
    hot_addr[5] = 16'h8000;
    for (int i = 6; i < 16; i++) hot_addr[i] = ADDR_W'($urandom_range(0, 65535));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(KIND_FLASH, 1'b0, 16'hD4BF);
    queue_access(OP_READ, 16'h0000, 8'h00);
    queue_access(OP_READ, 16'hFFFF, 8'hFF);
    queue_command(CMD_ID_ENTER);
    queue_access(OP_READ, 16'h0000, 8'h00);
    queue_access(OP_READ, 16'h0001, 8'h00);
    // The unlock sequence still runs in ID mode.
    queue_command(CMD_PROGRAM);
    queue_access(OP_WRITE, 16'hFFFF, 8'h00);
    queue_access(OP_READ, 16'hFFFF, 8'h00);
    // Wrong byte at the second step, a stray write while unlocked, then an
    // erase byte outside erase mode, which is an unknown command.
    queue_access(OP_WRITE, CMD_ADDR, UNLOCK1_BYTE);
    queue_access(OP_WRITE, UNLOCK2_ADDR, 8'h54);
    queue_access(OP_WRITE, UNLOCK2_ADDR, UNLOCK2_BYTE);
    queue_access(OP_WRITE, 16'h1234, 8'h77);
    queue_access(OP_WRITE, CMD_ADDR, CMD_SECTOR_ERASE);
    // Bank select is refused on a small chip.
    queue_command(CMD_BANK_SELECT);
    queue_command(CMD_ERASE);
    queue_unlock();
    queue_access(OP_WRITE, CMD_ADDR, CMD_CHIP_ERASE);
    queue_access(OP_READ, 16'hFFFF, 8'h00);

    configure(KIND_FLASH, 1'b1, 16'hFFFF);
    gen_flash_traffic(350, 1'b1);
    configure(KIND_SRAM, 1'b0, 16'h0000);
    gen_plain_traffic(200);
    configure(KIND_NONE, 1'b0, 16'h0000);
    gen_plain_traffic(100);
    configure(KIND_UNUSED, 1'b1, ID_W'($urandom_range(0, 65535)));
    gen_plain_traffic(60);
    configure(KIND_FLASH, 1'b0, ID_W'($urandom_range(0, 65535)));
    gen_flash_traffic(300, 1'b0);
    configure(KIND_SRAM, 1'b1, 16'h5AA5);
    gen_plain_traffic(100);
    configure(KIND_FLASH, 1'b1, 16'h8001);
    gen_flash_traffic(150, 1'b0);

    wait_quiet();
    if (mismatches == 0 && rdata_due.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Bus driver: bursts of items with random gaps, holding when asked.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (bus_plan.size() != 0 &&
                   !(bus_plan[0].hold && (outstanding != 0 || in_valid_i))) begin
        next_access = bus_plan.pop_front();
        op_i       <= next_access.op;
        addr_i     <= next_access.addr;
        wdata_i    <= next_access.data;
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: stalls results in one of four styles, redrawn at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_tick % 256 == 0) stall_style = 2'($urandom_range(0, 3));
      case (stall_style)
        STALL_NONE:   out_ready_i <= 1'b1;
        STALL_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        STALL_SPARSE: out_ready_i <= (stall_tick % 5 == 0);
        default:      out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Monitor: tracks register writes, predicts each accepted item and checks
  // each result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SAVE_KIND: cfg_kind = cfg_data_i[1:0];
          CFG_BIG_FLASH: cfg_big = cfg_data_i[0];
          CFG_DEVICE_ID: cfg_id = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (rdata_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got rdata %02h", $time, rdata_o);
          mismatches++;
        end else begin
          due_rdata = rdata_due.pop_front();
          if (rdata_o !== due_rdata) begin
            $display("%0t: rdata mismatch, expected %02h, got %02h", $time, due_rdata,
                     rdata_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        rdata_due.push_back(access_save_mirror(op_i, addr_i, wdata_i));
      end
      outstanding <= outstanding + int'(in_valid_i && in_ready_o)
                     - int'(out_valid_o && out_ready_i);
    end
  end

  // Watchdog for a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

endmodule
